>>> src/lpfs_pkg.sv
// Shared types and constants for the length-prefixed frame splitter.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lpfs_pkg;

   // Configuration register reset values and register indexes
   localparam logic [15:0] RESET_MIN_LENGTH = 16'd16;
   localparam logic [15:0] RESET_MAX_LENGTH = 16'd20480;  // 16 KiB + 4 KiB

   localparam logic CSR_IDX_MIN_LENGTH = 1'b0;
   localparam logic CSR_IDX_MAX_LENGTH = 1'b1;

   // Result queue geometry
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = 2;
   localparam int unsigned FIFO_CNT_W = 3;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       msg_start;
      logic       msg_last;
      logic       length_error;
   } lpfs_result_type;

   // Results produced by one accepted input byte (zero, one or two)
   typedef struct packed {
      logic [1:0]      count;
      lpfs_result_type first;
      lpfs_result_type second;
   } lpfs_push_type;

endpackage

`default_nettype wire

>>> src/lpfs_parser.sv
// Header parser and body counter of the frame splitter.
// Depends on lpfs_pkg for the result and push types.
`default_nettype none

module lpfs_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic [15:0]           min_length,
   input  wire logic [15:0]           max_length,
   output lpfs_pkg::lpfs_push_type    push
);
   import lpfs_pkg::*;

   typedef enum logic [1:0] {
      PH_LOW  = 2'd0,
      PH_HIGH = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_low_ff, held_low_in;
   logic [15:0] msg_len_ff, msg_len_in;
   logic [15:0] seen_ff, seen_in;

   logic [15:0] hdr_len;
   logic [15:0] seen_next;
   logic        hdr_bad;

   assign hdr_len   = {in_byte, held_low_ff};
   assign hdr_bad   = (hdr_len < min_length) || (hdr_len > max_length);
   assign seen_next = seen_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      held_low_in = held_low_ff;
      msg_len_in  = msg_len_ff;
      seen_in     = seen_ff;
      push        = '0;
      if (accept) begin
         case (phase_ff)
            PH_HIGH: begin
               if (hdr_bad) begin
                  // one error transaction, then look for a new header
                  push.count              = 2'd1;
                  push.first.length_error = 1'b1;
                  phase_in                = PH_LOW;
                  msg_len_in              = '0;
                  seen_in                 = '0;
               end else begin
                  push.count           = 2'd2;
                  push.first.out_byte  = held_low_ff;
                  push.first.msg_start = 1'b1;
                  push.second.out_byte = in_byte;
                  push.second.msg_last = (hdr_len <= 16'd2);
                  msg_len_in           = hdr_len;
                  seen_in              = 16'd2;
                  phase_in             = (hdr_len <= 16'd2) ? PH_LOW : PH_BODY;
               end
            end
            PH_BODY: begin
               push.count          = 2'd1;
               push.first.out_byte = in_byte;
               push.first.msg_last = (seen_next >= msg_len_ff);
               seen_in             = seen_next;
               if (seen_next >= msg_len_ff) begin
                  phase_in = PH_LOW;
               end
            end
            default: begin
               // hold the low length byte; no result yet
               held_low_in = in_byte;
               phase_in    = PH_HIGH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LOW;
         held_low_ff <= '0;
         msg_len_ff  <= '0;
         seen_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_low_ff <= held_low_in;
         msg_len_ff  <= msg_len_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

`default_nettype wire

>>> src/lpfs_result_fifo.sv
// Four-entry result queue: takes up to two transactions per cycle, gives one while out_stall is low.
// Depends on lpfs_pkg for the result and push types and the queue geometry.
`default_nettype none

module lpfs_result_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lpfs_pkg::lpfs_push_type push,
   output logic                         almost_full,
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output lpfs_pkg::lpfs_result_type    out_result
);
   import lpfs_pkg::*;

   lpfs_result_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   pop;
   logic [FIFO_PTR_W-1:0]  wr_ptr_second;

   assign out_valid     = (count_ff != '0);
   assign out_result    = mem_ff[rd_ptr_ff];
   assign pop           = out_valid && !out_stall;
   // stall the input unless two free entries remain
   assign almost_full   = (count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_ptr_second = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_second] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         ({1'b0, count_ff} + (FIFO_CNT_W+1)'(push.count)) <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_pop_drains : assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - FIFO_CNT_W'(1))
      else $error("pop without push did not drain one entry");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      count_ff < FIFO_CNT_W'(FIFO_DEPTH) |->
         FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == FIFO_PTR_W'(count_ff))
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

>>> src/length_prefixed_frame_splitter.sv
// Length-prefixed frame splitter: top level with the configuration registers.
// Depends on lpfs_pkg, lpfs_parser and lpfs_result_fifo.
//
// Usage:
//   req_* carries the raw byte stream, one byte per transaction. A message
//   opens with a 16-bit little-endian length that counts the whole message.
//   The low length byte is held and gives no result; the high byte gives two
//   result transactions (both header bytes, the first flagged msg_start) or,
//   if the length falls outside [min_length, max_length], one transaction
//   with length_error set and a zero byte. Body bytes pass through one for
//   one; the byte that completes the length is flagged msg_last.
//   Results pass through the queue registers to rsp_*; a header's second result follows its first.
//   Throughput: one byte per cycle while rsp_stall stays low; the parser
//   handles each byte as it is taken and results land in a four-entry queue
//   that can take two per cycle and return one.
//   Stall: when rsp_stall holds results back, the queue fills and req_stall
//   rises once fewer than two entries are free; the held rsp_* payload stays.
//   Reset: synchronous; empties the queue, returns the parser to waiting for
//   a length byte and loads min_length = 16, max_length = 20480.
//   Registers (APB, 32-bit data): min_length at 0x0, max_length at 0x4;
//   write them only while the block is idle.
`default_nettype none

module length_prefixed_frame_splitter (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   // message bytes out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_msg_start,
   output logic             rsp_msg_last,
   output logic             rsp_length_error,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import lpfs_pkg::*;

   logic [15:0]     min_length_ff, min_length_in;
   logic [15:0]     max_length_ff, max_length_in;
   logic            csr_write;
   logic            csr_idx;
   logic            accept;
   lpfs_push_type   push;
   lpfs_result_type result;

   // Configuration registers; word index sits in paddr[2]
   assign pready    = 1'b1;
   assign csr_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      min_length_in = min_length_ff;
      max_length_in = max_length_ff;
      if (csr_write) begin
         case (csr_idx)
            CSR_IDX_MIN_LENGTH: min_length_in = pwdata[15:0];
            CSR_IDX_MAX_LENGTH: max_length_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IDX_MIN_LENGTH: prdata = {16'd0, min_length_ff};
         CSR_IDX_MAX_LENGTH: prdata = {16'd0, max_length_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= RESET_MIN_LENGTH;
         max_length_ff <= RESET_MAX_LENGTH;
      end else begin
         min_length_ff <= min_length_in;
         max_length_ff <= max_length_in;
      end
   end

   // Take a byte whenever the queue has room for two results
   assign accept = req_valid && !req_stall;

   lpfs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .min_length (min_length_ff),
      .max_length (max_length_ff),
      .push       (push)
   );

   lpfs_result_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .almost_full (req_stall),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_result  (result)
   );

   assign rsp_out_byte     = result.out_byte;
   assign rsp_msg_start    = result.msg_start;
   assign rsp_msg_last     = result.msg_last;
   assign rsp_length_error = result.length_error;

endmodule

`default_nettype wire

>>> bench/lpfs_frame_checker.sv
`timescale 1ns / 1ps
// Frame splitter scoreboard: tracks the byte stream, register writes and results.
// Needs lpfs_pkg for the result layout, register indexes and reset values.
module lpfs_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_msg_start,
   input  wire logic        rsp_msg_last,
   input  wire logic        rsp_length_error,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               failures,
   output int               pending_results
);
   import lpfs_pkg::*;

   typedef enum logic [1:0] {
      WAIT_LOW  = 2'd0,
      WAIT_HIGH = 2'd1,
      IN_BODY   = 2'd2
   } frame_phase_type;

   logic [15:0]     min_length_q;
   logic [15:0]     max_length_q;
   frame_phase_type phase_q;
   logic [7:0]      held_low_q;
   logic [15:0]     frame_length_q;
   logic [15:0]     bytes_seen_q;
   lpfs_result_type frame_bytes_q[$];
   int              mismatches = 0;

   // Append one expected result at the tail of the queue.
   function automatic void queue_result(input lpfs_result_type r);
      frame_bytes_q = {frame_bytes_q, r};
   endfunction

   // Advance the framing state by one byte and queue the bytes it releases.
   function automatic void split_byte(input logic [7:0] b);
      logic [15:0] len;
      logic        last;
      case (phase_q)
         WAIT_HIGH: begin
            len = {b, held_low_q};
            if (len < min_length_q || len > max_length_q) begin
               queue_result(lpfs_result_type'{8'h00, 1'b0, 1'b0, 1'b1});
               phase_q        = WAIT_LOW;
               frame_length_q = '0;
               bytes_seen_q   = '0;
            end else begin
               last           = (len <= 16'd2);
               frame_length_q = len;
               bytes_seen_q   = 16'd2;
               queue_result(lpfs_result_type'{held_low_q, 1'b1, 1'b0, 1'b0});
               queue_result(lpfs_result_type'{b, 1'b0, last, 1'b0});
               phase_q        = last ? WAIT_LOW : IN_BODY;
            end
         end
         IN_BODY: begin
            bytes_seen_q = bytes_seen_q + 16'd1;
            last         = (bytes_seen_q >= frame_length_q);
            queue_result(lpfs_result_type'{b, 1'b0, last, 1'b0});
            if (last) begin
               phase_q = WAIT_LOW;
            end
         end
         default: begin
            held_low_q = b;
            phase_q    = WAIT_HIGH;
         end
      endcase
   endfunction

   always @(posedge clock) begin : score
      lpfs_result_type want;
      if (reset) begin
         min_length_q   = RESET_MIN_LENGTH;
         max_length_q   = RESET_MAX_LENGTH;
         phase_q        = WAIT_LOW;
         held_low_q     = '0;
         frame_length_q = '0;
         bytes_seen_q   = '0;
         frame_bytes_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_q.size() == 0) begin
               $error("unexpected result: out_byte %02h start %0b last %0b error %0b",
                      rsp_out_byte, rsp_msg_start, rsp_msg_last, rsp_length_error);
               mismatches++;
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_msg_start !== want.msg_start) begin
                  $error("msg_start: expected %0b, actual %0b", want.msg_start, rsp_msg_start);
                  mismatches++;
               end
               if (rsp_msg_last !== want.msg_last) begin
                  $error("msg_last: expected %0b, actual %0b", want.msg_last, rsp_msg_last);
                  mismatches++;
               end
               if (rsp_length_error !== want.length_error) begin
                  $error("length_error: expected %0b, actual %0b",
                         want.length_error, rsp_length_error);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            split_byte(req_in_byte);
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_IDX_MIN_LENGTH) begin
               min_length_q = pwdata[15:0];
            end else if (paddr[2] == CSR_IDX_MAX_LENGTH) begin
               max_length_q = pwdata[15:0];
            end
         end
      end
      failures        <= mismatches;
      pending_results <= frame_bytes_q.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Bench top for the frame splitter: clock, reset, register setup, byte stream
// and result back-pressure. Needs lpfs_pkg, the splitter and lpfs_frame_checker.
module tb;
   import lpfs_pkg::*;

   // Longest quiet spell of a correct run is a long result stall on top of a
   // long sender gap; the limit is set far above that.
   localparam int IDLE_LIMIT = 2000;
   // Cap on generated message lengths so that wide length windows stay quick.
   localparam int MAX_BODY   = 64;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = 3'd0;
   logic [31:0] pwdata      = 32'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_msg_start;
   logic        rsp_msg_last;
   logic        rsp_length_error;
   logic [31:0] prdata;
   logic        pready;

   int          failures;
   int          pending_results;

   int          items_sent  = 0;
   int          burst_left  = 0;
   int          stall_left  = 0;
   int          idle_cycles = 0;
   logic [15:0] frame_min   = RESET_MIN_LENGTH;
   logic [15:0] frame_max   = RESET_MAX_LENGTH;

   length_prefixed_frame_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_msg_start    (rsp_msg_start),
      .rsp_msg_last     (rsp_msg_last),
      .rsp_length_error (rsp_length_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   lpfs_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_msg_start    (rsp_msg_start),
      .rsp_msg_last     (rsp_msg_last),
      .rsp_length_error (rsp_length_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .failures         (failures),
      .pending_results  (pending_results)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result back-pressure: runs of free flow, short stalls, the odd long
   // stall that fills the queue and pushes back on the sender, and long
   // stretches with no stall at all.
   always @(posedge clock) begin : rsp_backpressure
      int r;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
         end else if (r < 85) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else if (r < 93) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(11, 39);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(30, 120);
         end
      end
   end

   // Watchdog: any accepted transaction or register access restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte and hold it until the splitter takes it. Keep valid high
   // between back-to-back bytes; drop it only for a gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      int r;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            gap = 0;
         end else if (r < 88) begin
            gap = $urandom_range(1, 3);
         end else if (r < 95) begin
            gap = $urandom_range(10, 40);
         end else begin
            // open a stretch of back-to-back bytes
            gap        = 0;
            burst_left = $urandom_range(40, 150);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // One APB write: setup, then access until pready. Leave psel high so a
   // second write can follow without a conflicting update in the same step.
   task automatic write_reg(input logic csr_idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {csr_idx, 2'b00};
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Program the length window; call only while the splitter is idle.
   task automatic set_lengths(input logic [15:0] lo, input logic [15:0] hi);
      write_reg(CSR_IDX_MIN_LENGTH, lo);
      write_reg(CSR_IDX_MAX_LENGTH, hi);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      frame_min  = lo;
      frame_max  = hi;
   endtask

   // Send a length header and, if the window takes it, the rest of the body.
   // An alternating body walks every data bit through both values.
   task automatic send_frame(input logic [15:0] len, input bit alternate);
      bit taken;
      taken = (len >= frame_min) && (len <= frame_max);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (taken) begin
         for (int i = 2; i < len; i++) begin
            send_byte(alternate ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom));
         end
      end
   endtask

   // Drop valid, let every predicted result drain, then let the splitter
   // settle before the next register write or the verdict.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random traffic for one length window: mostly well-formed messages with
   // random content where the window holds a length up to MAX_BODY, else none;
   // the rest rejected headers (just outside either edge, or any out-of-window value).
   task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi, input int count);
      int          stop_at;
      int          top;
      int          r;
      logic [15:0] len;
      set_lengths(lo, hi);
      stop_at = items_sent + count;
      top     = (hi < MAX_BODY) ? hi : MAX_BODY;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (lo <= hi && lo <= MAX_BODY && r < 80) begin
            if (r < 12) begin
               len = lo;
            end else if (r < 24 && hi <= MAX_BODY) begin
               len = hi;
            end else begin
               len = 16'($urandom_range(lo, top));
            end
         end else begin
            len = 16'($urandom);
            if (r < 90 || (len >= lo && len <= hi)) begin
               len = (hi < 16'hFFFF && r[0]) ? hi + 16'd1 : lo - 16'd1;
            end
         end
         send_frame(len, 1'b0);
      end
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Widest window: two-byte message ends on its own header, short body,
      // lengths of zero and one rejected.
      set_lengths(16'd2, 16'hFFFF);
      send_frame(16'd2, 1'b0);
      send_frame(16'd4, 1'b1);
      send_frame(16'd0, 1'b0);
      send_frame(16'd1, 1'b0);
      wait_idle();

      // Reset window: one below min, one above max, all-ones length, exact min.
      set_lengths(RESET_MIN_LENGTH, RESET_MAX_LENGTH);
      send_frame(RESET_MIN_LENGTH - 16'd1, 1'b0);
      send_frame(RESET_MAX_LENGTH + 16'd1, 1'b0);
      send_frame(16'hFFFF, 1'b0);
      send_frame(RESET_MIN_LENGTH, 1'b1);
      wait_idle();

      // Random part across narrow, wide, inverted and extreme windows.
      run_phase(16'd2, 16'd2, 230);
      run_phase(16'd3, 16'd40, 230);
      run_phase(16'd5, 16'd5, 230);
      run_phase(RESET_MIN_LENGTH, RESET_MAX_LENGTH, 230);
      run_phase(16'd300, 16'd200, 230);
      run_phase(16'hFFFF, 16'hFFFF, 230);
      run_phase(16'd2, 16'hFFFF, 230);

      if (failures == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
